// ===== src/los_pkg.sv =====
// ----------------------------------------------------------------------------
// los_pkg: shared types for the last occurrence search block
// Request and result payloads, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package los_pkg;

  // request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // fixed field widths
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 11;

  typedef struct packed {
    logic                       operation;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch key and open the search range
    logic write;   // store request value in the table
    logic read;    // latch midpoint and read the table there
    logic update;  // compare read entry with key and narrow the range
    logic finish;  // present the result for one cycle
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic range_open;  // lo < end
  } status_t;

endpackage

`default_nettype wire

// ===== src/los_ctrl.sv =====
// ----------------------------------------------------------------------------
// los_ctrl: search sequencer
// Accepts requests, steps the datapath through read and compare cycles
// of each probe and ends the search when the range is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module los_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             operation,
  input  wire los_pkg::status_t status,
  output los_pkg::cmd_t         cmd,
  output logic                  busy
);

  los_pkg::state_t state;
  los_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= los_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      los_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation == los_pkg::OP_QUERY) begin
            cmd.load   = 1'b1;
            state_next = los_pkg::ST_PROBE;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      los_pkg::ST_PROBE: begin
        if (status.range_open) begin
          cmd.read   = 1'b1;
          state_next = los_pkg::ST_COMPARE;
        end else begin
          cmd.finish = 1'b1;
          state_next = los_pkg::ST_IDLE;
        end
      end
      los_pkg::ST_COMPARE: begin
        cmd.update = 1'b1;
        state_next = los_pkg::ST_PROBE;
      end
      default: begin
        state_next = los_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/los_datapath.sv =====
// ----------------------------------------------------------------------------
// los_datapath: table memory and search range
// Holds the table, the element count register, the lo and end bounds,
// the key and the running hit, and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module los_datapath #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire los_pkg::cmd_t                cmd,
  input  wire los_pkg::req_t                request,
  input  wire logic                         cfg_we,
  input  wire logic [los_pkg::COUNT_W-1:0]  cfg_data,
  output los_pkg::status_t                  status,
  output logic                              done,
  output los_pkg::rsp_t                     result
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [los_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];

  logic [los_pkg::COUNT_W-1:0]       element_count;
  logic [CW-1:0]                     lo;
  logic [CW-1:0]                     end_pos;
  logic [AW-1:0]                     mid;
  logic [AW-1:0]                     mid_next;
  logic [CW:0]                       span_sum;
  logic [CW-1:0]                     count_sat;
  logic signed [los_pkg::VALUE_W-1:0] key;
  logic signed [los_pkg::VALUE_W-1:0] rdata;
  logic                              hit;
  logic [AW-1:0]                     where;
  logic                              write_ok;

  // element count register
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (cfg_we) begin
      element_count <= cfg_data;
    end
  end

  // count saturated to the table depth
  always_comb begin
    if (32'(element_count) > 32'(TABLE_DEPTH)) begin
      count_sat = CW'(TABLE_DEPTH);
    end else begin
      count_sat = CW'(element_count);
    end
  end

  // midpoint of the inclusive range lo .. end-1
  assign span_sum = (CW + 1)'(lo) + (CW + 1)'(end_pos) - (CW + 1)'(1);
  assign mid_next = AW'(span_sum[CW:1]);

  assign status.range_open = (lo < end_pos);

  // table write port, out of range indexes dropped
  assign write_ok = (32'(request.index) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.write && write_ok) begin
      mem[AW'(request.index)] <= request.value;
    end
  end

  // table read port
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rdata <= $signed(mem[mid_next]);
    end
  end

  // search range, key and running hit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo      <= '0;
      end_pos <= count_sat;
      key     <= request.value;
      hit     <= 1'b0;
      where   <= '0;
    end
    if (cmd.read) begin
      mid <= mid_next;
    end
    if (cmd.update) begin
      if (rdata == key) begin
        hit   <= 1'b1;
        where <= mid;
        lo    <= CW'(mid) + CW'(1);
      end else if (rdata > key) begin
        end_pos <= CW'(mid);
      end else begin
        lo <= CW'(mid) + CW'(1);
      end
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.found    <= hit;
      result.position <= hit ? los_pkg::INDEX_W'(where) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/last_occurrence_search.sv =====
// ----------------------------------------------------------------------------
// last_occurrence_search: binary search for the last match in a sorted table
// Stores table entries on write requests and answers query requests with
// a found flag and the index of the last entry equal to the key.
// ----------------------------------------------------------------------------
//
//   channel   ports                    handshake
//   -------   ----------------------   -----------------------------------
//   request   start, busy, request     taken when start is high, busy low
//   result    done, result             one-cycle strobe, no back pressure
//   config    cfg_we, cfg_data         written when cfg_we is high
//
// A write request leaves busy low.
// A query keeps busy high for p probes of the table, p <= ceil(log2(n+1))
// for n entries in use: each probe is a registered memory read followed by
// a compare, and a closing step follows the last probe.
// The result strobe comes in the first cycle with busy low again; a new
// request may be taken in that same cycle. Reset clears the controller and
// the count; the table itself holds nothing defined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module last_occurrence_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire los_pkg::req_t                request,
  output logic                              done,
  output los_pkg::rsp_t                     result,
  input  wire logic                         cfg_we,
  input  wire logic [los_pkg::COUNT_W-1:0]  cfg_data
);

  los_pkg::cmd_t    cmd;
  los_pkg::status_t status;

  // sequencer
  los_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (request.operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // table and search datapath
  los_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .status   (status),
    .done     (done),
    .result   (result)
  );

  // a result only closes a running search
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a search in progress");

  // a query request starts a search
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.operation == los_pkg::OP_QUERY) |=> busy)
    else $error("query request did not start a search");

  // a write request leaves the block idle and gives no result
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.operation == los_pkg::OP_WRITE) |=> (!busy && !done))
    else $error("write request started a search");

  // a miss reports position zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.position == '0))
    else $error("miss with nonzero position");

  // a hit lies inside the table
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (32'(result.position) < 32'(TABLE_DEPTH)))
    else $error("hit position beyond the table");

endmodule

`default_nettype wire
